// ===== rtl/vn3_pkg.sv =====
// vn3_pkg: shared constants and types for the 3d value noise pipeline
// fixed point format, hash constants, stage count and inter-module structs
// no dependencies
`default_nettype none

package vn3_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int HASH_W    = 64;
	localparam int VAL_W     = 24;
	localparam int IN_W      = 3 * COORD_W + HASH_W;
	localparam int OUT_W     = VAL_W;
	localparam int PROD_W    = VAL_W + FRAC_BITS + 2;
	localparam int NSTAGE    = 12;

	localparam logic [HASH_W-1:0] HASH_K1 = 64'h9E3779B97F4A7C15;
	localparam logic [HASH_W-1:0] HASH_K2 = 64'hBF58476D1CE4E5B9;
	localparam logic [HASH_W-1:0] HASH_K3 = 64'h94D049BB133111EB;

	typedef struct packed {
		logic [FRAC_BITS-1:0] tx;
		logic [FRAC_BITS-1:0] ty;
		logic [FRAC_BITS-1:0] tz;
	} frac3_t;

	typedef struct packed {
		logic mul;
		logic add;
	} stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/value_noise_3d.sv =====
// value_noise_3d: trilinear value noise over a hashed 3d lattice
// twelve stage pipeline built from vn3_mix and vn3_lerp
// depends on vn3_pkg, vn3_mix, vn3_lerp
//
// usage
//   input stream s_axis carries one point per item: three signed q16.16
//   coordinates and a 64-bit seed. output stream m_axis carries one
//   24-bit q0.24 noise sample per item, in input order.
//   throughput is one item per cycle when the
//   receiver keeps up.
//   stages: lattice cell, coordinate partial products, coordinate
//   products, corner xor and fold, two mix stages, then two stages
//   each for the x, y and z blends.
//   when the receiver stalls, the last stage holds its result and the
//   stages before it keep filling empty slots; s_axis_tready drops once
//   every stage holds an item. nothing is lost or repeated.
//   reset (arst_n low) empties the pipeline; s_axis_tready is high and
//   m_axis_tvalid low right after reset.
`default_nettype none

module value_noise_3d import vn3_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// coord_x[31:0], coord_y[63:32], coord_z[95:64], noise_seed[159:96]
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// noise_value[23:0]
	output logic      [OUT_W-1:0] m_axis_tdata
);

	localparam logic [HASH_W-1:0] AXIS_K [3] = '{HASH_K1, HASH_K2, HASH_K3};

	logic [NSTAGE:1] v_q;
	logic [NSTAGE:1] en;

	logic [COORD_W-1:0] cell_d   [6];
	logic [COORD_W-1:0] cell_s1  [6];
	logic [HASH_W-1:0]  plo_s2   [6];
	logic [31:0]        phi_s2   [6];
	logic [HASH_W-1:0]  prod_s3  [6];
	logic [HASH_W-1:0]  h_d      [8];
	logic [HASH_W-1:0]  h_s4     [8];
	logic [VAL_W-1:0]   corner   [8];
	logic [VAL_W-1:0]   lx       [4];
	logic [VAL_W-1:0]   ly       [2];
	logic [VAL_W-1:0]   lz;

	logic [HASH_W-1:0] seed_s1, seed_s2, seed_s3;
	frac3_t w_d;
	frac3_t w_s1, w_s2, w_s3, w_s4, w_s5, w_s6, w_s7, w_s8, w_s9, w_s10;

	// stall chain: a stage moves when it is empty or the next one moves
	always_comb begin
		en[NSTAGE] = !v_q[NSTAGE] || m_axis_tready;
		for (int i = NSTAGE - 1; i >= 1; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= s_axis_tvalid;
			for (int i = 2; i <= NSTAGE; i++) begin
				if (en[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = v_q[NSTAGE];
	assign m_axis_tdata  = lz;

	// lattice cell and weights
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cell_d[2*a]   = COORD_W'($signed(s_axis_tdata[a*COORD_W +: COORD_W]) >>> FRAC_BITS);
			cell_d[2*a+1] = cell_d[2*a] + COORD_W'(1);
		end
		w_d.tx = s_axis_tdata[0*COORD_W +: FRAC_BITS];
		w_d.ty = s_axis_tdata[1*COORD_W +: FRAC_BITS];
		w_d.tz = s_axis_tdata[2*COORD_W +: FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cell_s1 <= cell_d;
			seed_s1 <= s_axis_tdata[3*COORD_W +: HASH_W];
			w_s1    <= w_d;
		end
	end

	// coordinate times constant, mod 2^64, as two partial products
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 6; i++) begin
				plo_s2[i] <= {32'b0, cell_s1[i]} * {32'b0, AXIS_K[i>>1][31:0]};
				phi_s2[i] <= cell_s1[i] * AXIS_K[i>>1][63:32];
			end
			seed_s2 <= seed_s1;
			w_s2    <= w_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 6; i++) begin
				prod_s3[i] <= plo_s2[i] + {phi_s2[i], 32'b0};
			end
			seed_s3 <= seed_s2;
			w_s3    <= w_s2;
		end
	end

	// corner k: bit 0 picks x, bit 1 picks y, bit 2 picks z
	always_comb begin
		logic [HASH_W-1:0] hx;
		for (int k = 0; k < 8; k++) begin
			hx = seed_s3 ^ prod_s3[k & 1] ^ prod_s3[2 + ((k >> 1) & 1)]
				^ prod_s3[4 + ((k >> 2) & 1)];
			h_d[k] = hx ^ (hx >> 30);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			h_s4 <= h_d;
			w_s4 <= w_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5])  w_s5  <= w_s4;
		if (en[6])  w_s6  <= w_s5;
		if (en[7])  w_s7  <= w_s6;
		if (en[8])  w_s8  <= w_s7;
		if (en[9])  w_s9  <= w_s8;
		if (en[10]) w_s10 <= w_s9;
	end

	generate
		for (genvar k = 0; k < 8; k++) begin : g_mix
			vn3_mix u_mix (
				.clk   (clk),
				.en    (stage_en_t'{mul: en[5], add: en[6]}),
				.h     (h_s4[k]),
				.value (corner[k])
			);
		end
		for (genvar j = 0; j < 4; j++) begin : g_lx
			vn3_lerp u_lerp (
				.clk (clk),
				.en  (stage_en_t'{mul: en[7], add: en[8]}),
				.a   (corner[2*j]),
				.b   (corner[2*j+1]),
				.t   (w_s6.tx),
				.r   (lx[j])
			);
		end
		for (genvar j = 0; j < 2; j++) begin : g_ly
			vn3_lerp u_lerp (
				.clk (clk),
				.en  (stage_en_t'{mul: en[9], add: en[10]}),
				.a   (lx[2*j]),
				.b   (lx[2*j+1]),
				.t   (w_s8.ty),
				.r   (ly[j])
			);
		end
	endgenerate

	vn3_lerp u_lz (
		.clk (clk),
		.en  (stage_en_t'{mul: en[11], add: en[12]}),
		.a   (ly[0]),
		.b   (ly[1]),
		.t   (w_s10.tz),
		.r   (lz)
	);

	// an empty output slot means every stage can move
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready while output stage is empty");

	// items in flight change only by accepts and deliveries
	a_item_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(v_q) == $past($countones(v_q))
			+ $past(int'(s_axis_tvalid && s_axis_tready))
			- $past(int'(m_axis_tvalid && m_axis_tready)))
		else $error("item count in pipeline inconsistent");

	// an item entering an empty pipeline reaches the output after the full depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && v_q == '0) |-> ##(NSTAGE) m_axis_tvalid)
		else $error("item did not reach output after pipeline depth");

endmodule

`default_nettype wire

// ===== rtl/vn3_mix.sv =====
// vn3_mix: final corner hash mix, multiply by the second constant and fold
// two register stages: 32x32 partial products, then sum and shift-xor
// depends on vn3_pkg
`default_nettype none

module vn3_mix import vn3_pkg::*; (
	input  wire logic              clk,
	input  wire stage_en_t         en,
	input  wire logic [HASH_W-1:0] h,
	output logic      [VAL_W-1:0]  value
);

	localparam logic [31:0] K_LO = HASH_K2[31:0];
	localparam logic [31:0] K_HI = HASH_K2[63:32];

	logic [HASH_W-1:0] ll_s1;
	logic [31:0]       lh_s1;
	logic [31:0]       hl_s1;
	logic [HASH_W-1:0] m;
	logic [HASH_W-1:0] f;

	always_ff @(posedge clk) begin
		if (en.mul) begin
			ll_s1 <= {32'b0, h[31:0]} * {32'b0, K_LO};
			lh_s1 <= h[31:0] * K_HI;
			hl_s1 <= h[63:32] * K_LO;
		end
	end

	always_comb begin
		m = ll_s1 + {lh_s1 + hl_s1, 32'b0};
		f = m ^ (m >> 27);
	end

	always_ff @(posedge clk) begin
		if (en.add) begin
			value <= f[HASH_W-1 -: VAL_W];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vn3_lerp.sv =====
// vn3_lerp: one linear blend a + floor((b - a) * t / 2^FRAC_BITS)
// two register stages: signed product, then shift and add
// depends on vn3_pkg
`default_nettype none

module vn3_lerp import vn3_pkg::*; (
	input  wire logic                 clk,
	input  wire stage_en_t            en,
	input  wire logic [VAL_W-1:0]     a,
	input  wire logic [VAL_W-1:0]     b,
	input  wire logic [FRAC_BITS-1:0] t,
	output logic      [VAL_W-1:0]     r
);

	logic signed [VAL_W:0]      d;
	logic signed [FRAC_BITS:0]  ts;
	logic signed [PROD_W-1:0]   p_s1;
	logic        [VAL_W-1:0]    a_s1;
	logic signed [PROD_W-1:0]   q;
	logic        [PROD_W-1:0]   sum;

	always_comb begin
		d  = $signed({1'b0, b}) - $signed({1'b0, a});
		ts = $signed({1'b0, t});
	end

	always_ff @(posedge clk) begin
		if (en.mul) begin
			p_s1 <= d * ts;
			a_s1 <= a;
		end
	end

	always_comb begin
		q   = p_s1 >>> FRAC_BITS;
		sum = $unsigned(q) + {{(PROD_W-VAL_W){1'b0}}, a_s1};
	end

	always_ff @(posedge clk) begin
		if (en.add) begin
			r <= sum[VAL_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== verif/value_noise_3d_tb.sv =====
// value_noise_3d_tb: self-checking bench for the 3d value noise pipeline
// predicts every sample from its own lattice hash and blend, checks items in order
// depends on vn3_pkg and value_noise_3d
`timescale 1ns / 1ps

module value_noise_3d_tb import vn3_pkg::*; ();

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// coord_x[31:0], coord_y[63:32], coord_z[95:64], noise_seed[159:96]
	logic [IN_W-1:0]      s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// noise_value[23:0]
	logic [OUT_W-1:0]     m_axis_tdata;

	logic [VAL_W-1:0]     noise_expected[$];
	logic [VAL_W-1:0]     noise_want;
	int                   sender_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   hold_seq = 0;
	int                   hold_seen = 0;
	int                   hold_left = 0;
	int                   idle_cycles = 0;
	int                   errors = 0;
	int                   n_sent = 0;
	int                   n_checked = 0;

	value_noise_3d i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic logic [VAL_W-1:0] lattice_hash(input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz,
			input logic [HASH_W-1:0] seed);
		logic [HASH_W-1:0] h;
		h = seed;
		h = h ^ ({32'b0, cx} * HASH_K1);
		h = h ^ ({32'b0, cy} * HASH_K2);
		h = h ^ ({32'b0, cz} * HASH_K3);
		h = h ^ (h >> 30);
		h = h * HASH_K2;
		h = h ^ (h >> 27);
		return h[63:40];
	endfunction

	// floor of a + (b - a) * t / 2^frac
	function automatic logic [VAL_W-1:0] weighted_blend(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b, input logic [FRAC_BITS-1:0] t);
		logic signed [63:0] diff;
		logic signed [63:0] prod;
		logic signed [63:0] sum;
		diff = $signed({40'b0, b}) - $signed({40'b0, a});
		prod = diff * $signed({{(64-FRAC_BITS){1'b0}}, t});
		sum  = $signed({40'b0, a}) + (prod >>> FRAC_BITS);
		return sum[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] noise_at(input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] pz,
			input logic [HASH_W-1:0] seed);
		logic [COORD_W-1:0]   x0, y0, z0, x1, y1, z1;
		logic [FRAC_BITS-1:0] tx, ty, tz;
		logic [VAL_W-1:0]     c00, c10, c01, c11;
		x0 = $signed(px) >>> FRAC_BITS;
		y0 = $signed(py) >>> FRAC_BITS;
		z0 = $signed(pz) >>> FRAC_BITS;
		x1 = x0 + 32'd1;
		y1 = y0 + 32'd1;
		z1 = z0 + 32'd1;
		tx = px[FRAC_BITS-1:0];
		ty = py[FRAC_BITS-1:0];
		tz = pz[FRAC_BITS-1:0];
		c00 = weighted_blend(lattice_hash(x0, y0, z0, seed), lattice_hash(x1, y0, z0, seed), tx);
		c10 = weighted_blend(lattice_hash(x0, y1, z0, seed), lattice_hash(x1, y1, z0, seed), tx);
		c01 = weighted_blend(lattice_hash(x0, y0, z1, seed), lattice_hash(x1, y0, z1, seed), tx);
		c11 = weighted_blend(lattice_hash(x0, y1, z1, seed), lattice_hash(x1, y1, z1, seed), tx);
		return weighted_blend(weighted_blend(c00, c10, ty), weighted_blend(c01, c11, ty), tz);
	endfunction

	function automatic logic [COORD_W-1:0] random_coord();
		logic [31:0] r;
		logic [15:0] f;
		r = $urandom;
		case ($urandom_range(3))
			0: return r;
			1: return {{12{r[19]}}, r[19:0]};
			2: begin
				case ($urandom_range(3))
					0: f = 16'h0000;
					1: f = 16'hFFFF;
					2: f = 16'h0001;
					default: f = 16'h8000;
				endcase
				return {r[31:16], f};
			end
			default: return $urandom_range(1) ? {16'h7FFF, r[15:0]} : {16'h8000, r[15:0]};
		endcase
	endfunction

	function automatic logic [HASH_W-1:0] random_seed();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
			input logic [COORD_W-1:0] pz, input logic [HASH_W-1:0] seed);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {seed, pz, py, px};
		do @(posedge clk); while (!s_axis_tready);
		noise_expected.push_back(noise_at(px, py, pz, seed));
		n_sent++;
	endtask

	task automatic test_lattice_extremes();
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		send_point(32'h00000000, 32'h00000000, 32'h00000000, 64'h0);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, '1);
		send_point(32'h80000000, 32'h80000000, 32'h80000000, 64'h0);
		send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, HASH_K1);
		// negative cells with zero weight
		send_point(32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 64'h1);
		send_point(32'h0000FFFF, 32'h0001FFFF, 32'hFFFEFFFF, HASH_K2);
		send_point(32'h80000000, 32'h7FFFFFFF, 32'h00000000, HASH_K3);
		send_point(32'h00000000, 32'h80000000, 32'h7FFFFFFF, 64'h8000000000000000);
		send_point(32'h00010000, 32'hFFFF8000, 32'h00008000, 64'hFFFFFFFF00000000);
		send_point(32'h12345678, 32'h9ABCDEF0, 32'h0FEDCBA9, 64'h0123456789ABCDEF);
		send_point(32'h00020001, 32'h00020001, 32'h00020001, 64'h00000000FFFFFFFF);
		send_point(32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF, 64'h5555555555555555);
		send_point(32'h7FFF0000, 32'h8000FFFF, 32'hFFFF0001, 64'hAAAAAAAAAAAAAAAA);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		repeat (count) send_point(random_coord(), random_coord(), random_coord(), random_seed());
	endtask

	// receiver holds off while the sender keeps offering, filling every stage
	task automatic test_output_hold_off();
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		hold_seq++;
		repeat (40) send_point(random_coord(), random_coord(), random_coord(), random_seed());
	endtask

	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (noise_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, actual %h", $time, m_axis_tdata);
			end else begin
				noise_want = noise_expected.pop_front();
				if (m_axis_tdata !== noise_want) begin
					errors++;
					$display("%0t: noise_value mismatch, expected %h, actual %h",
						$time, noise_want, m_axis_tdata);
				end
			end
			n_checked++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_lattice_extremes();
		test_random_phase(0, 0, 250);
		test_random_phase(69, 0, 250);
		test_random_phase(0, 69, 250);
		test_random_phase(17, 17, 250);
		test_output_hold_off();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		recv_stall_pct = 0;
		while (noise_expected.size() != 0) @(posedge clk);
		repeat (3 * NSTAGE) @(posedge clk);
		$display("sent %0d points: lattice extremes, four stall mixes and a long output hold-off",
			n_sent);
		$display("compared %0d noise samples, %0d mismatches", n_checked, errors);
		if (errors == 0 && noise_expected.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
